[hw/rtl/sac_pkg.sv]
// Shared types, codes and helper functions of the set-associative write-back cache.
package sac_pkg;

    // Request type codes on the input channel.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // Length of a full memory word in bytes.
    localparam logic [2:0] LEN_WORD = 3'd4;

    // Result kinds on the output channel.
    typedef enum logic [2:0] {
        KIND_READ     = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_WB       = 3'd2,
        KIND_WT       = 3'd3,
        KIND_FILL_REQ = 3'd4,
        KIND_CROSS    = 3'd5,
        KIND_UNEXP    = 3'd6
    } kind_t;

    // Classification made by the front end.
    typedef enum logic [1:0] {
        CLS_ACCESS = 2'd0,
        CLS_FILL   = 2'd1,
        CLS_CROSS  = 2'd2,
        CLS_BAD    = 2'd3
    } cls_t;

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        cls_t        cls;
        logic        is_write;
        logic [31:0] addr;
        logic [2:0]  len;
        logic [31:0] wdata;
        logic [31:0] fill_word;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] mem_addr;
        logic [31:0] mem_data;
        logic [2:0]  mem_len;
        logic [31:0] rdata;
        logic        was_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic        last;
    } res_t;

    // Byte mask that keeps the low len bytes of a word.
    function automatic logic [31:0] len_mask(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/sac_fifo.sv]
// Two-entry queue used between the front end, the back end and the result port.
module sac_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    // Status flags and the head entry.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/sac_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module sac_front #(
    parameter int LINE_OFFSET_BITS = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    req_type,
    input  logic [31:0]   addr,
    input  logic [2:0]    len,
    input  logic [31:0]   wdata,
    input  logic [31:0]   fill_word,
    input  logic          cmd_pop,
    output logic          cmd_empty,
    output sac_pkg::cmd_t cmd
);

    localparam int LINE_BYTES = 1 << LINE_OFFSET_BITS;
    localparam int POS_W      = LINE_OFFSET_BITS + 1;

    logic             q_full;
    logic [POS_W-1:0] end_pos;
    logic             crosses;
    logic             bad_len;
    sac_pkg::cmd_t    cmd_in;

    // The queue accepts nothing while the back end is still clearing its valid and dirty rows.
    assign full = q_full || !enable;

    // Check whether the access runs past the end of its line.
    assign end_pos = {1'b0, addr[LINE_OFFSET_BITS-1:0]} + POS_W'(len);
    assign crosses = (end_pos > POS_W'(LINE_BYTES));
    assign bad_len = (len == 3'd0) || (len > sac_pkg::LEN_WORD);

    // Classify the request; a refill word wins over every other check.
    always_comb
    begin
        cmd_in.is_write  = (req_type == sac_pkg::REQ_WRITE);
        cmd_in.addr      = addr;
        cmd_in.len       = len;
        cmd_in.wdata     = wdata;
        cmd_in.fill_word = fill_word;
        if (req_type == sac_pkg::REQ_FILL)
        begin
            cmd_in.cls = sac_pkg::CLS_FILL;
        end
        else if ((req_type != sac_pkg::REQ_READ && req_type != sac_pkg::REQ_WRITE) || bad_len)
        begin
            cmd_in.cls = sac_pkg::CLS_BAD;
        end
        else if (crosses)
        begin
            cmd_in.cls = sac_pkg::CLS_CROSS;
        end
        else
        begin
            cmd_in.cls = sac_pkg::CLS_ACCESS;
        end
    end

    // Command queue toward the back end.
    sac_fifo #(
        .WIDTH ($bits(sac_pkg::cmd_t))
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && !full),
        .wr_data (cmd_in),
        .full    (q_full),
        .pop     (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

endmodule

[hw/rtl/sac_back.sv]
// Back end: tag lookup, data access, write-back, refill sequencing and result generation.
module sac_back #(
    parameter int LINE_OFFSET_BITS = 6,
    parameter int WAY_BITS         = 4,
    parameter int SET_BITS         = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    output logic          ready,
    input  sac_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output sac_pkg::res_t res,
    output logic          res_push,
    input  logic          res_full
);

    localparam int NUM_WAYS   = 1 << WAY_BITS;
    localparam int WB         = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int WORD_BITS  = LINE_OFFSET_BITS - 2;
    localparam int LINE_BYTES = 1 << LINE_OFFSET_BITS;
    localparam int TAG_W      = 32 - LINE_OFFSET_BITS - SET_BITS;
    localparam int DA_W       = SET_BITS + WAY_BITS + WORD_BITS;
    localparam int DATA_DEPTH = 1 << DA_W;
    localparam logic [WORD_BITS-1:0] LAST_WORD = '1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOOKUP,
        S_WB_RD,
        S_WB_EMIT,
        S_WT_EMIT,
        S_REQ_EMIT,
        S_FILL_TAG,
        S_ACC_RD0,
        S_ACC_RD1,
        S_ACC_CALC,
        S_ACC_WR1,
        S_ACC_EMIT,
        S_EMIT_ERR
    } state_t;

    // Control and payload registers.
    state_t                  state_reg;
    logic [SET_BITS-1:0]     clr_cnt_reg;
    sac_pkg::cmd_t           cur_reg;
    sac_pkg::cmd_t           pend_reg;
    logic                    pending_reg;
    logic [WB-1:0]           pend_way_reg;
    logic [WORD_BITS-1:0]    fill_cnt_reg;
    logic [31:0]             hit_cnt_reg;
    logic [31:0]             miss_cnt_reg;
    logic [WB-1:0]           op_way_reg;
    logic                    hit_flag_reg;
    logic [2*NUM_WAYS-1:0]   vd_row_reg;
    logic [TAG_W-1:0]        vtag_reg;
    logic [WORD_BITS-1:0]    wb_idx_reg;
    logic [31:0]             w0_reg;
    logic [31:0]             w1_reg;
    logic [31:0]             rdata_reg;
    sac_pkg::kind_t          err_kind_reg;

    // Memories and their registered read data.
    logic [2*NUM_WAYS-1:0]     vd_mem   [NUM_SETS];
    logic [NUM_WAYS*TAG_W-1:0] tag_mem  [NUM_SETS];
    logic [31:0]               data_mem [DATA_DEPTH];
    logic [2*NUM_WAYS-1:0]     vd_q;
    logic [NUM_WAYS*TAG_W-1:0] tag_q;
    logic [31:0]               data_q;

    // Memory port controls.
    logic                      vd_re;
    logic [SET_BITS-1:0]       vd_raddr;
    logic                      vd_we;
    logic [SET_BITS-1:0]       vd_waddr;
    logic [2*NUM_WAYS-1:0]     vd_wdata;
    logic                      tag_we;
    logic [NUM_WAYS*TAG_W-1:0] tag_wdata;
    logic                      dm_re;
    logic [DA_W-1:0]           dm_raddr;
    logic                      dm_we;
    logic [DA_W-1:0]           dm_waddr;
    logic [31:0]               dm_wdata;

    // Address fields of the current and the pending access.
    logic [LINE_OFFSET_BITS-1:0] cur_off;
    logic [SET_BITS-1:0]         cur_set;
    logic [TAG_W-1:0]            cur_tag;
    logic [WORD_BITS-1:0]        cur_word;
    logic [WORD_BITS-1:0]        next_word;
    logic [SET_BITS-1:0]         pend_set;
    logic [TAG_W-1:0]            pend_tag;

    // Lookup results.
    logic [NUM_WAYS-1:0] valid_q;
    logic [NUM_WAYS-1:0] dirty_q;
    logic                hit_any;
    logic [WB-1:0]       hit_way;
    logic [WB-1:0]       victim;
    logic [NUM_WAYS-1:0] victim_oh;
    logic [NUM_WAYS-1:0] pend_oh;
    logic [NUM_WAYS-1:0] op_oh;
    logic [NUM_WAYS*TAG_W-1:0] tag_row_new;

    // Byte merge of the two words touched by an access.
    logic [4:0]  sh_bits;
    logic [31:0] acc_mask;
    logic [63:0] pair;
    logic [31:0] rd_val;
    logic [63:0] wmask64;
    logic [63:0] wdat64;
    logic [63:0] merged;
    logic [31:0] wb_addr;

    function automatic logic [DA_W-1:0] dat_addr(
        input logic [SET_BITS-1:0]  s,
        input logic [WB-1:0]        w,
        input logic [WORD_BITS-1:0] i
    );
        return (DA_W'(s) << (WAY_BITS + WORD_BITS)) | (DA_W'(w) << WORD_BITS) | DA_W'(i);
    endfunction

    assign cur_off   = cur_reg.addr[LINE_OFFSET_BITS-1:0];
    assign cur_set   = cur_reg.addr[LINE_OFFSET_BITS +: SET_BITS];
    assign cur_tag   = cur_reg.addr[31 -: TAG_W];
    assign cur_word  = cur_off[LINE_OFFSET_BITS-1:2];
    assign next_word = cur_word + WORD_BITS'(1);
    assign pend_set  = pend_reg.addr[LINE_OFFSET_BITS +: SET_BITS];
    assign pend_tag  = pend_reg.addr[31 -: TAG_W];

    assign ready   = (state_reg != S_CLEAR);
    assign cmd_pop = (state_reg == S_IDLE) && !cmd_empty;

    // Tag compare over all ways, first hit and first free way.
    assign valid_q = vd_q[NUM_WAYS-1:0];
    assign dirty_q = vd_q[2*NUM_WAYS-1 -: NUM_WAYS];

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        victim  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid_q[w] && (tag_q[w*TAG_W +: TAG_W] == cur_tag))
            begin
                hit_any = 1'b1;
                hit_way = WB'(w);
            end
            if (!valid_q[w])
            begin
                victim = WB'(w);
            end
        end
    end

    assign victim_oh = NUM_WAYS'(1) << victim;
    assign pend_oh   = NUM_WAYS'(1) << pend_way_reg;
    assign op_oh     = NUM_WAYS'(1) << op_way_reg;

    // Tag row with the refilled way replaced.
    always_comb
    begin
        tag_row_new = tag_q;
        tag_row_new[pend_way_reg*TAG_W +: TAG_W] = pend_tag;
    end

    // Read extraction and write merge across two adjacent words.
    assign sh_bits  = {cur_off[1:0], 3'b000};
    assign acc_mask = sac_pkg::len_mask(cur_reg.len);
    assign pair     = {data_q, w0_reg};
    assign rd_val   = 32'(pair >> sh_bits) & acc_mask;
    assign wmask64  = {32'b0, acc_mask} << sh_bits;
    assign wdat64   = {32'b0, cur_reg.wdata & acc_mask} << sh_bits;
    assign merged   = (pair & ~wmask64) | wdat64;

    assign wb_addr = (32'(vtag_reg) << (LINE_OFFSET_BITS + SET_BITS))
                   | (32'(cur_set) << LINE_OFFSET_BITS)
                   | (32'(wb_idx_reg) << 2);

    // Memory port selection per state.
    always_comb
    begin
        vd_re     = 1'b0;
        vd_raddr  = cur_set;
        vd_we     = 1'b0;
        vd_waddr  = cur_set;
        vd_wdata  = '0;
        tag_we    = 1'b0;
        tag_wdata = tag_row_new;
        dm_re     = 1'b0;
        dm_raddr  = dat_addr(cur_set, op_way_reg, cur_word);
        dm_we     = 1'b0;
        dm_waddr  = dat_addr(cur_set, op_way_reg, cur_word);
        dm_wdata  = merged[31:0];
        case (state_reg)
            S_CLEAR:
            begin
                vd_we    = 1'b1;
                vd_waddr = clr_cnt_reg;
            end
            S_DECODE:
            begin
                if (cur_reg.cls == sac_pkg::CLS_FILL && pending_reg)
                begin
                    dm_we    = 1'b1;
                    dm_waddr = dat_addr(pend_set, pend_way_reg, fill_cnt_reg);
                    dm_wdata = cur_reg.fill_word;
                    if (fill_cnt_reg == LAST_WORD)
                    begin
                        vd_re    = 1'b1;
                        vd_raddr = pend_set;
                    end
                end
                else if (cur_reg.cls == sac_pkg::CLS_ACCESS && !pending_reg)
                begin
                    vd_re = 1'b1;
                end
            end
            S_LOOKUP:
            begin
                if (!hit_any)
                begin
                    vd_we    = 1'b1;
                    vd_wdata = {dirty_q & ~victim_oh, valid_q & ~victim_oh};
                end
            end
            S_WB_RD:
            begin
                dm_re    = 1'b1;
                dm_raddr = dat_addr(cur_set, op_way_reg, wb_idx_reg);
            end
            S_FILL_TAG:
            begin
                vd_we    = 1'b1;
                vd_waddr = pend_set;
                vd_wdata = {dirty_q & ~pend_oh, valid_q | pend_oh};
                tag_we   = 1'b1;
            end
            S_ACC_RD0:
            begin
                dm_re = 1'b1;
            end
            S_ACC_RD1:
            begin
                dm_re    = 1'b1;
                dm_raddr = dat_addr(cur_set, op_way_reg, next_word);
            end
            S_ACC_CALC:
            begin
                dm_we = cur_reg.is_write;
            end
            S_ACC_WR1:
            begin
                dm_we    = 1'b1;
                dm_waddr = dat_addr(cur_set, op_way_reg, next_word);
                dm_wdata = w1_reg;
                if (hit_flag_reg)
                begin
                    vd_we    = 1'b1;
                    vd_wdata = {vd_row_reg[2*NUM_WAYS-1 -: NUM_WAYS] | op_oh,
                                vd_row_reg[NUM_WAYS-1:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result transaction for the emitting states.
    always_comb
    begin
        res.kind       = sac_pkg::KIND_UNEXP;
        res.mem_addr   = '0;
        res.mem_data   = '0;
        res.mem_len    = '0;
        res.rdata      = '0;
        res.was_hit    = 1'b0;
        res.hit_total  = hit_cnt_reg;
        res.miss_total = miss_cnt_reg;
        res.last       = 1'b0;
        res_push       = 1'b0;
        case (state_reg)
            S_EMIT_ERR:
            begin
                res.kind = err_kind_reg;
                res.last = 1'b1;
                res_push = !res_full;
            end
            S_WB_EMIT:
            begin
                res.kind     = sac_pkg::KIND_WB;
                res.mem_addr = wb_addr;
                res.mem_data = data_q;
                res.mem_len  = sac_pkg::LEN_WORD;
                res_push     = !res_full;
            end
            S_WT_EMIT:
            begin
                res.kind     = sac_pkg::KIND_WT;
                res.mem_addr = cur_reg.addr;
                res.mem_data = cur_reg.wdata & acc_mask;
                res.mem_len  = cur_reg.len;
                res_push     = !res_full;
            end
            S_REQ_EMIT:
            begin
                res.kind     = sac_pkg::KIND_FILL_REQ;
                res.mem_addr = cur_reg.addr & ~32'(LINE_BYTES - 1);
                res.last     = 1'b1;
                res_push     = !res_full;
            end
            S_ACC_EMIT:
            begin
                res.kind    = cur_reg.is_write ? sac_pkg::KIND_WRITE : sac_pkg::KIND_READ;
                res.rdata   = cur_reg.is_write ? 32'd0 : rdata_reg;
                res.was_hit = hit_flag_reg;
                res.last    = 1'b1;
                res_push    = !res_full;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state and its registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            cur_reg      <= '0;
            pend_reg     <= '0;
            pending_reg  <= 1'b0;
            pend_way_reg <= '0;
            fill_cnt_reg <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            op_way_reg   <= '0;
            hit_flag_reg <= 1'b0;
            vd_row_reg   <= '0;
            vtag_reg     <= '0;
            wb_idx_reg   <= '0;
            w0_reg       <= '0;
            w1_reg       <= '0;
            rdata_reg    <= '0;
            err_kind_reg <= sac_pkg::KIND_UNEXP;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SET_BITS'(1);
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        cur_reg   <= cmd;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    case (cur_reg.cls)
                        sac_pkg::CLS_FILL:
                        begin
                            err_kind_reg <= sac_pkg::KIND_UNEXP;
                            if (!pending_reg)
                            begin
                                state_reg <= S_EMIT_ERR;
                            end
                            else if (fill_cnt_reg == LAST_WORD)
                            begin
                                fill_cnt_reg <= '0;
                                state_reg    <= S_FILL_TAG;
                            end
                            else
                            begin
                                fill_cnt_reg <= fill_cnt_reg + WORD_BITS'(1);
                                state_reg    <= S_IDLE;
                            end
                        end
                        sac_pkg::CLS_CROSS:
                        begin
                            // A crossing access while a miss is open is simply busy.
                            err_kind_reg <= pending_reg ? sac_pkg::KIND_UNEXP
                                                        : sac_pkg::KIND_CROSS;
                            state_reg    <= S_EMIT_ERR;
                        end
                        sac_pkg::CLS_ACCESS:
                        begin
                            err_kind_reg <= sac_pkg::KIND_UNEXP;
                            state_reg    <= pending_reg ? S_EMIT_ERR : S_LOOKUP;
                        end
                        default:
                        begin
                            err_kind_reg <= sac_pkg::KIND_UNEXP;
                            state_reg    <= S_EMIT_ERR;
                        end
                    endcase
                end
                S_LOOKUP:
                begin
                    vd_row_reg <= vd_q;
                    if (hit_any)
                    begin
                        hit_cnt_reg  <= hit_cnt_reg + 32'd1;
                        op_way_reg   <= hit_way;
                        hit_flag_reg <= 1'b1;
                        state_reg    <= S_ACC_RD0;
                    end
                    else
                    begin
                        miss_cnt_reg <= miss_cnt_reg + 32'd1;
                        op_way_reg   <= victim;
                        hit_flag_reg <= 1'b0;
                        vtag_reg     <= tag_q[victim*TAG_W +: TAG_W];
                        wb_idx_reg   <= '0;
                        if (valid_q[victim] && dirty_q[victim])
                        begin
                            state_reg <= S_WB_RD;
                        end
                        else if (cur_reg.is_write)
                        begin
                            state_reg <= S_WT_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_REQ_EMIT;
                        end
                    end
                end
                S_WB_RD:
                begin
                    state_reg <= S_WB_EMIT;
                end
                S_WB_EMIT:
                begin
                    if (!res_full)
                    begin
                        wb_idx_reg <= wb_idx_reg + WORD_BITS'(1);
                        if (wb_idx_reg != LAST_WORD)
                        begin
                            state_reg <= S_WB_RD;
                        end
                        else if (cur_reg.is_write)
                        begin
                            state_reg <= S_WT_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_REQ_EMIT;
                        end
                    end
                end
                S_WT_EMIT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_REQ_EMIT;
                    end
                end
                S_REQ_EMIT:
                begin
                    if (!res_full)
                    begin
                        pending_reg  <= 1'b1;
                        pend_reg     <= cur_reg;
                        pend_way_reg <= op_way_reg;
                        fill_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_FILL_TAG:
                begin
                    pending_reg  <= 1'b0;
                    cur_reg      <= pend_reg;
                    op_way_reg   <= pend_way_reg;
                    hit_flag_reg <= 1'b0;
                    state_reg    <= S_ACC_RD0;
                end
                S_ACC_RD0:
                begin
                    state_reg <= S_ACC_RD1;
                end
                S_ACC_RD1:
                begin
                    w0_reg    <= data_q;
                    state_reg <= S_ACC_CALC;
                end
                S_ACC_CALC:
                begin
                    rdata_reg <= rd_val;
                    w1_reg    <= merged[63:32];
                    state_reg <= cur_reg.is_write ? S_ACC_WR1 : S_ACC_EMIT;
                end
                S_ACC_WR1:
                begin
                    state_reg <= S_ACC_EMIT;
                end
                S_ACC_EMIT:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT_ERR:
                begin
                    if (!res_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Valid and dirty bits, one row per set.
    always_ff @(posedge clk)
    begin
        if (vd_we)
        begin
            vd_mem[vd_waddr] <= vd_wdata;
        end
        if (vd_re)
        begin
            vd_q <= vd_mem[vd_raddr];
        end
    end

    // Tags, one row per set.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[pend_set] <= tag_wdata;
        end
        if (vd_re)
        begin
            tag_q <= tag_mem[vd_raddr];
        end
    end

    // Line data, one word per entry.
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            data_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            data_q <= data_mem[dm_raddr];
        end
    end

`ifndef SYNTH
    // A result is only produced when the result queue can take it.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // Refill words are only counted while a miss is outstanding.
    a_fill_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_cnt_reg != '0) |-> pending_reg)
        else $error("refill count without a pending miss");

    // Issuing a fill request leaves a miss pending.
    a_req_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == sac_pkg::KIND_FILL_REQ) |=> pending_reg)
        else $error("fill request did not mark a pending miss");
`endif

endmodule

[hw/rtl/set_assoc_writeback_cache.sv]
// Top level of the set-associative write-back, write-allocate cache.
//
// Request channel: push with full; a transaction is taken when push is high and full low.
// Each request is a read, a write, or one refill word from memory (req_type).
// Result channel: empty with pop; the oldest result is shown while empty is low and
// is taken when pop is high. Every request yields its results in order, the final one
// flagged by last; refill words other than the last of a line yield nothing.
// Sequencing: one request is worked on at a time. The back-end sequencer reads the tag
// row, compares, then makes two word reads and up to two word writes on the data
// memory. A miss first writes back each word of a dirty victim (16 words at the default
// size), reading each word before it is emitted; each refill word is taken from the
// request queue and decoded on its own.
// Reset: the valid and dirty rows are cleared one set per cycle, all 4096 sets at the
// default size; full stays high until that pass is done. Counters restart at zero.
// Stall: when the receiver does not pop, results collect in a two-entry queue, then the
// sequencer waits, and the two-entry request queue fills and raises full.
module set_assoc_writeback_cache #(
    parameter int LINE_OFFSET_BITS = 6,
    parameter int WAY_BITS         = 4,
    parameter int SET_BITS         = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [31:0] addr,
    input  logic [2:0]  len,
    input  logic [31:0] wdata,
    input  logic [31:0] fill_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [31:0] mem_addr,
    output logic [31:0] mem_data,
    output logic [2:0]  mem_len,
    output logic [31:0] rdata,
    output logic        was_hit,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic        last
);

    logic          ready;
    sac_pkg::cmd_t cmd;
    logic          cmd_empty;
    logic          cmd_pop;
    sac_pkg::res_t res_in;
    logic          res_push;
    logic          res_full;
    sac_pkg::res_t res_out;

    // Request decode and queue.
    sac_front #(
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (ready),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .addr      (addr),
        .len       (len),
        .wdata     (wdata),
        .fill_word (fill_word),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd       (cmd)
    );

    // Cache engine.
    sac_back #(
        .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
        .WAY_BITS         (WAY_BITS),
        .SET_BITS         (SET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ready     (ready),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_in),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue toward the receiver.
    sac_fifo #(
        .WIDTH ($bits(sac_pkg::res_t))
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    // Result fields.
    assign kind       = res_out.kind;
    assign mem_addr   = res_out.mem_addr;
    assign mem_data   = res_out.mem_data;
    assign mem_len    = res_out.mem_len;
    assign rdata      = res_out.rdata;
    assign was_hit    = res_out.was_hit;
    assign hit_total  = res_out.hit_total;
    assign miss_total = res_out.miss_total;
    assign last       = res_out.last;

endmodule

[bench/set_assoc_writeback_cache_checker.sv]
// Checker for the set-associative write-back cache: predicts results and compares them.
`timescale 1ns / 1ps

module set_assoc_writeback_cache_checker #(
    parameter int LINE_OFFSET_BITS = 6,
    parameter int WAY_BITS         = 4,
    parameter int SET_BITS         = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  req_type,
    input  logic [31:0] addr,
    input  logic [2:0]  len,
    input  logic [31:0] wdata,
    input  logic [31:0] fill_word,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  kind,
    input  logic [31:0] mem_addr,
    input  logic [31:0] mem_data,
    input  logic [2:0]  mem_len,
    input  logic [31:0] rdata,
    input  logic        was_hit,
    input  logic [31:0] hit_total,
    input  logic [31:0] miss_total,
    input  logic        last,
    output int          fail_count,
    output int          exp_count,
    output logic        line_fill_due
);

    localparam int NWAYS      = 1 << WAY_BITS;
    localparam int NSETS      = 1 << SET_BITS;
    localparam int LBYTES     = 1 << LINE_OFFSET_BITS;
    localparam int LWORDS     = 1 << (LINE_OFFSET_BITS - 2);
    localparam int NLINES     = 1 << (WAY_BITS + SET_BITS);
    localparam int TAG_SHIFT  = LINE_OFFSET_BITS + SET_BITS;

    // Predicted cache contents.
    bit                 valid_row [NLINES];
    bit                 dirty_row [NLINES];
    logic [31:0]        tag_store [int unsigned];
    logic [31:0]        word_store [int unsigned];

    // Predicted miss bookkeeping and counters.
    logic               miss_open;
    logic [1:0]         miss_type;
    logic [31:0]        miss_addr;
    logic [2:0]         miss_len;
    logic [31:0]        miss_wdata;
    int unsigned        miss_way;
    int unsigned        fill_idx;
    logic [31:0]        hits;
    logic [31:0]        misses;

    sac_pkg::res_t      expected_results [$];
    int                 reported;

    assign exp_count     = expected_results.size();
    assign line_fill_due = miss_open;

    function automatic logic [31:0] keep_mask(input logic [2:0] n);
        if (n >= 3'd4)
            return 32'hFFFF_FFFF;
        return (32'h1 << (8 * n)) - 32'h1;
    endfunction

    // Appends one predicted result; counters are taken after the item's update.
    function automatic void add_result(input sac_pkg::kind_t k, input logic [31:0] ma,
                                       input logic [31:0] md, input logic [2:0] ml,
                                       input logic [31:0] rd, input logic h);
        sac_pkg::res_t r;
        r.kind       = k;
        r.mem_addr   = ma;
        r.mem_data   = md;
        r.mem_len    = ml;
        r.rdata      = rd;
        r.was_hit    = h;
        r.hit_total  = hits;
        r.miss_total = misses;
        r.last       = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic logic [31:0] line_read(input int unsigned ln, input int unsigned off,
                                              input logic [2:0] n);
        logic [31:0] v;
        logic [31:0] w;
        int unsigned b;
        v = '0;
        for (int j = 0; j < n; j++)
        begin
            b = off + j;
            w = word_store[ln * LWORDS + (b >> 2)];
            v |= ((w >> (8 * (b & 3))) & 32'hFF) << (8 * j);
        end
        return v;
    endfunction

    function automatic void line_write(input int unsigned ln, input int unsigned off,
                                       input logic [2:0] n, input logic [31:0] d);
        int unsigned b;
        int unsigned i;
        int unsigned sh;
        for (int j = 0; j < n; j++)
        begin
            b  = off + j;
            i  = ln * LWORDS + (b >> 2);
            sh = 8 * (b & 3);
            word_store[i] = (word_store[i] & ~(32'hFF << sh)) |
                            (((d >> (8 * j)) & 32'hFF) << sh);
        end
    endfunction

    // Works out the results of one accepted request and updates the predicted state.
    function automatic void predict_request(input logic [1:0] t, input logic [31:0] a,
                                            input logic [2:0] n, input logic [31:0] d,
                                            input logic [31:0] fw);
        int unsigned off;
        int unsigned set_i;
        int unsigned base;
        int unsigned ln;
        int unsigned hit_way;
        int unsigned victim;
        logic [31:0] tg;
        logic [31:0] vaddr;
        int          first;
        first = expected_results.size();
        if (t == sac_pkg::REQ_FILL && miss_open)
        begin
            // Refill word: store it, complete the access on the final word.
            set_i = (miss_addr >> LINE_OFFSET_BITS) & (NSETS - 1);
            ln    = (set_i << WAY_BITS) | miss_way;
            off   = miss_addr & (LBYTES - 1);
            word_store[ln * LWORDS + fill_idx] = fw;
            if (fill_idx + 1 < LWORDS)
            begin
                fill_idx++;
                return;
            end
            fill_idx      = 0;
            miss_open     = 1'b0;
            valid_row[ln] = 1'b1;
            dirty_row[ln] = 1'b0;
            tag_store[ln] = miss_addr >> TAG_SHIFT;
            if (miss_type == sac_pkg::REQ_WRITE)
            begin
                line_write(ln, off, miss_len, miss_wdata);
                add_result(sac_pkg::KIND_WRITE, '0, '0, '0, '0, 1'b0);
            end
            else
                add_result(sac_pkg::KIND_READ, '0, '0, '0, line_read(ln, off, miss_len), 1'b0);
        end
        else if (t >= sac_pkg::REQ_FILL || miss_open || n == 3'd0 || n > 3'd4)
            add_result(sac_pkg::KIND_UNEXP, '0, '0, '0, '0, 1'b0);
        else if ((a & (LBYTES - 1)) + n > LBYTES)
            add_result(sac_pkg::KIND_CROSS, '0, '0, '0, '0, 1'b0);
        else
        begin
            off     = a & (LBYTES - 1);
            set_i   = (a >> LINE_OFFSET_BITS) & (NSETS - 1);
            tg      = a >> TAG_SHIFT;
            base    = set_i << WAY_BITS;
            hit_way = NWAYS;
            for (int w = 0; w < NWAYS; w++)
            begin
                if (valid_row[base + w] && tag_store[base + w] == tg)
                begin
                    hit_way = w;
                    break;
                end
            end
            if (hit_way < NWAYS)
            begin
                // Hit: answer at once.
                ln = base + hit_way;
                hits++;
                if (t == sac_pkg::REQ_WRITE)
                begin
                    line_write(ln, off, n, d);
                    dirty_row[ln] = 1'b1;
                    add_result(sac_pkg::KIND_WRITE, '0, '0, '0, '0, 1'b1);
                end
                else
                    add_result(sac_pkg::KIND_READ, '0, '0, '0, line_read(ln, off, n), 1'b1);
            end
            else
            begin
                // Miss: pick a victim, write it back if dirty, send a write through, then ask for a fill.
                misses++;
                victim = 0;
                for (int w = 0; w < NWAYS; w++)
                begin
                    if (!valid_row[base + w])
                    begin
                        victim = w;
                        break;
                    end
                end
                ln = base + victim;
                if (valid_row[ln] && dirty_row[ln])
                begin
                    vaddr = (tag_store[ln] << TAG_SHIFT) | (set_i << LINE_OFFSET_BITS);
                    for (int w = 0; w < LWORDS; w++)
                        add_result(sac_pkg::KIND_WB, vaddr + 4 * w,
                                   word_store[ln * LWORDS + w],
                                   sac_pkg::LEN_WORD, '0, 1'b0);
                end
                valid_row[ln] = 1'b0;
                dirty_row[ln] = 1'b0;
                if (t == sac_pkg::REQ_WRITE)
                    add_result(sac_pkg::KIND_WT, a, d & keep_mask(n), n, '0, 1'b0);
                add_result(sac_pkg::KIND_FILL_REQ, a & ~(LBYTES - 1), '0, '0, '0, 1'b0);
                miss_open  = 1'b1;
                miss_type  = t;
                miss_addr  = a;
                miss_len   = n;
                miss_wdata = d;
                miss_way   = victim;
                fill_idx   = 0;
            end
        end
        if (expected_results.size() > first)
            expected_results[$].last = 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        fail_count++;
        if (reported < 10)
            $display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
        reported++;
    endfunction

    // Predict on every accepted request and compare every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        sac_pkg::res_t e;
        if (!rst_n)
        begin
            valid_row  = '{default: 1'b0};
            dirty_row  = '{default: 1'b0};
            miss_open  = 1'b0;
            miss_type  = '0;
            miss_addr  = '0;
            miss_len   = '0;
            miss_wdata = '0;
            miss_way   = 0;
            fill_idx   = 0;
            hits       = '0;
            misses     = '0;
            fail_count = 0;
            reported   = 0;
            expected_results.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (reported < 10)
                        $display("result transaction with nothing expected: kind %0d", kind);
                    reported++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (kind != e.kind)
                        note_mismatch("kind", e.kind, kind);
                    if (mem_addr != e.mem_addr)
                        note_mismatch("mem_addr", e.mem_addr, mem_addr);
                    if (mem_data != e.mem_data)
                        note_mismatch("mem_data", e.mem_data, mem_data);
                    if (mem_len != e.mem_len)
                        note_mismatch("mem_len", e.mem_len, mem_len);
                    if (rdata != e.rdata)
                        note_mismatch("rdata", e.rdata, rdata);
                    if (was_hit != e.was_hit)
                        note_mismatch("was_hit", e.was_hit, was_hit);
                    if (hit_total != e.hit_total)
                        note_mismatch("hit_total", e.hit_total, hit_total);
                    if (miss_total != e.miss_total)
                        note_mismatch("miss_total", e.miss_total, miss_total);
                    if (last != e.last)
                        note_mismatch("last", e.last, last);
                end
            end
            if (push && !full)
                predict_request(req_type, addr, len, wdata, fill_word);
        end
    end

endmodule

[bench/set_assoc_writeback_cache_tb.sv]
// Top of the cache testbench: stimulus, result draining, watchdog and verdict.
`timescale 1ns / 1ps

module set_assoc_writeback_cache_tb;

    localparam int IDLE_LIMIT = 40000;
    localparam int RANDOM_ACCESSES = 290;
    localparam int ITEM_BUDGET = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  req_type = sac_pkg::REQ_READ;
    logic [31:0] addr = '0;
    logic [2:0]  len = 3'd1;
    logic [31:0] wdata = '0;
    logic [31:0] fill_word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  kind;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
    logic [2:0]  mem_len;
    logic [31:0] rdata;
    logic        was_hit;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        last;
    int          fail_count;
    int          exp_count;
    logic        line_fill_due;

    int          burst_left = 0;
    int          idle_cycles = 0;
    int          n_access = 0;
    int          n_refills = 0;
    int          n_noise = 0;
    int          n_sent = 0;
    logic [13:0] tag_pool [20];

    set_assoc_writeback_cache uut (.*);

    set_assoc_writeback_cache_checker chk (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: pops in randomly chosen modes, including long stalls.
    always @(posedge clk)
    begin
        int unsigned mode_cnt;
        int unsigned mode;
        if (mode_cnt % 64 == 0)
            mode = $urandom_range(0, 3);
        mode_cnt++;
        case (mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 1) == 1);
            2:       pop <= ($urandom_range(0, 9) == 0);
            default: pop <= ((mode_cnt % 32) >= 20);
        endcase
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", exp_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one request, in bursts with random gaps, and waits until it is taken.
    task automatic send(input logic [1:0] t, input logic [31:0] a, input logic [2:0] n,
                        input logic [31:0] d, input logic [31:0] fw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        n_sent++;
        push      <= 1'b1;
        req_type  <= t;
        addr      <= a;
        len       <= n;
        wdata     <= d;
        fill_word <= fw;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stops offering requests until every expected result has been taken.
    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (exp_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // One access; a miss is followed by a refill, with an occasional busy request inside.
    task automatic access(input logic [1:0] t, input logic [31:0] a, input logic [2:0] n,
                          input logic [31:0] d);
        send(t, a, n, d, $urandom);
        n_access++;
        drain();
        if (line_fill_due)
        begin
            for (int w = 0; w < 16; w++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    send(2'($urandom_range(0, 1)), $urandom, 3'($urandom_range(1, 4)),
                         $urandom, $urandom);
                    n_noise++;
                end
                send(sac_pkg::REQ_FILL, $urandom, 3'($urandom_range(0, 7)), $urandom,
                     $urandom);
                n_refills++;
            end
            drain();
        end
    endtask

    function automatic logic [31:0] pick_addr();
        logic [13:0] tg;
        logic [11:0] st;
        case ($urandom_range(0, 4))
            0:       st = 12'd0;
            1:       st = 12'd1;
            2:       st = 12'hFFF;
            3:       st = 12'd0;
            default: st = 12'($urandom);
        endcase
        tg = ($urandom_range(0, 7) == 0) ? 14'($urandom) : tag_pool[$urandom_range(0, 19)];
        return {tg, st, 6'($urandom_range(0, 63))};
    endfunction

    initial
    begin
        logic [31:0] a;
        logic [2:0]  n;
        for (int i = 0; i < 20; i++)
            tag_pool[i] = 14'($urandom);
        tag_pool[0] = 14'h0000;
        tag_pool[1] = 14'h3FFF;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: misses, hits, extremes and each odd request.
        access(sac_pkg::REQ_READ, 32'h0000_0000, 3'd4, '0);
        access(sac_pkg::REQ_READ, 32'h0000_0000, 3'd4, '0);
        access(sac_pkg::REQ_WRITE, 32'h0000_0005, 3'd3, 32'hFFFF_FFFF);
        access(sac_pkg::REQ_READ, 32'h0000_0004, 3'd4, '0);
        access(sac_pkg::REQ_WRITE, 32'hFFFF_FFFC, 3'd4, 32'hFFFF_FFFF);
        access(sac_pkg::REQ_READ, 32'hFFFF_FFFF, 3'd1, '0);
        access(sac_pkg::REQ_WRITE, 32'hFFFF_FFC0, 3'd2, 32'hA5A5_5A5A);
        access(sac_pkg::REQ_READ, 32'h0000_003D, 3'd4, '0);
        access(sac_pkg::REQ_WRITE, 32'hFFFF_FFFE, 3'd3, 32'h1234_5678);
        access(sac_pkg::REQ_READ, 32'h0000_0010, 3'd0, '0);
        access(sac_pkg::REQ_READ, 32'h0000_0010, 3'd5, '0);
        access(sac_pkg::REQ_WRITE, 32'h0000_0010, 3'd7, 32'hFFFF_FFFF);
        access(sac_pkg::REQ_RSVD, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF);
        access(sac_pkg::REQ_FILL, 32'h0, 3'd1, 32'h0);
        send(sac_pkg::REQ_READ, 32'h1234_0040, 3'd2, '0, '0);
        n_access++;
        send(sac_pkg::REQ_WRITE, 32'h1234_0044, 3'd1, 32'hFF, '0);
        n_noise++;
        for (int w = 0; w < 16; w++)
        begin
            send(sac_pkg::REQ_FILL, '0, '0, '0, (w == 0) ? 32'hFFFF_FFFF : $urandom);
            n_refills++;
        end
        drain();

        // Random part: mostly well-formed accesses on a few crowded sets.
        for (int i = 0; i < RANDOM_ACCESSES && n_sent < ITEM_BUDGET; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                n_noise++;
                case ($urandom_range(0, 3))
                    0:       access(sac_pkg::REQ_FILL, $urandom,
                                    3'($urandom_range(0, 7)), $urandom);
                    1:       access(sac_pkg::REQ_RSVD, $urandom,
                                    3'($urandom_range(0, 7)), $urandom);
                    2:       access(2'($urandom_range(0, 1)), $urandom,
                                    ($urandom_range(0, 1) == 1) ? 3'd0 : 3'($urandom_range(5, 7)),
                                    $urandom);
                    default: access(2'($urandom_range(0, 1)), {$urandom} | 32'h3E,
                                    3'($urandom_range(3, 4)), $urandom);
                endcase
            end
            else
            begin
                a = pick_addr();
                n = 3'($urandom_range(1, 4));
                if ((a & 32'h3F) + n > 64)
                    a = a & ~32'h3;
                access(2'($urandom_range(0, 1)), a, n, $urandom);
            end
        end

        // Let the block settle after the last result.
        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d accesses, %0d refill words and %0d odd requests",
                 n_access, n_refills, n_noise);
        $display("final counters: %0d hits, %0d misses", hit_total, miss_total);
        if (fail_count == 0 && exp_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
